// ===== design/wos_pkg.sv =====
// shared types, constants and the exp2 table builder for the wavetable oscillator
`timescale 1ns / 1ps
package wos_pkg;

  localparam int unsigned MaxFrames   = 32;
  localparam int unsigned MaxFrameLen = 1024;
  localparam int unsigned PhaseBits   = 24;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned AddrBits    = 15;
  localparam int unsigned RomSize     = 3072;
  localparam logic [63:0] RomStep     = 64'd1073984124;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ENABLED       = 3'd0,
    REG_SMOOTH        = 3'd1,
    REG_DETUNE        = 3'd2,
    REG_REF_INCREMENT = 3'd3,
    REG_FRAME_COUNT   = 3'd4,
    REG_FRAME_LENGTH  = 3'd5
  } cfg_reg_e;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } load_t;

  typedef logic [30:0] exp_rom_t [RomSize];

  // 2^(k/3072) in q1.30, each entry rounded from the previous one
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    r;
    logic [63:0] acc;
    acc  = 64'd1 << 30;
    r[0] = acc[30:0];
    for (int k = 1; k < RomSize; k++) begin
      acc  = (acc * RomStep + (64'd1 << 29)) >> 30;
      r[k] = acc[30:0];
    end
    return r;
  endfunction

endpackage

// ===== design/wos_pitch.sv =====
// phase increment pipeline: octave split, exp2 rom, scale products, shift and saturate
`timescale 1ns / 1ps
module wos_pitch import wos_pkg::*; (
  input  logic               clk_i,
  input  load_t              ld_i,
  input  logic [6:0]         note_i,
  input  logic signed [15:0] detune_i,
  input  logic [23:0]        ref_increment_i,
  input  logic [15:0]        pitch_scale_i,
  input  logic [15:0]        fm_scale_i,
  output logic [23:0]        incr_o
);

  localparam exp_rom_t ExpRom = build_exp_rom();

  logic signed [17:0] e_full;
  logic [16:0]        e_val;
  logic [12:0]        x43;
  logic [5:0]         oct_d;
  logic [16:0]        rem_full;
  logic [54:0]        ref_prod;
  logic [5:0]         shamt;
  logic [62:0]        shifted;

  logic [5:0]  oct1_q, oct2_q, oct3_q, oct4_q, oct5_q;
  logic [11:0] rem1_q;
  logic [15:0] ps1_q, ps2_q, ps3_q;
  logic [15:0] fs1_q, fs2_q, fs3_q, fs4_q;
  logic [30:0] rom2_q;
  logic [30:0] p3_q;
  logic [46:0] p4_q;
  logic [62:0] p5_q;

  // exponent offset so it stays positive, then divide by 3072 via (e>>10)/3
  assign e_full   = $signed({3'b000, note_i, 8'h00}) + 18'(detune_i) + 18'sd34560;
  assign e_val    = e_full[16:0];
  assign x43      = 13'(e_val[16:10]) * 13'd43;
  assign oct_d    = x43[12:7];
  assign rem_full = e_val - 17'(oct_d) * 17'd3072;
  assign ref_prod = 55'(ref_increment_i) * 55'(rom2_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      oct1_q <= oct_d;
      rem1_q <= rem_full[11:0];
      ps1_q  <= pitch_scale_i;
      fs1_q  <= fm_scale_i;
    end
    if (ld_i.s2) begin
      oct2_q <= oct1_q;
      rom2_q <= ExpRom[rem1_q];
      ps2_q  <= ps1_q;
      fs2_q  <= fs1_q;
    end
    if (ld_i.s3) begin
      oct3_q <= oct2_q;
      p3_q   <= ref_prod[54:24];
      ps3_q  <= ps2_q;
      fs3_q  <= fs2_q;
    end
    if (ld_i.s4) begin
      oct4_q <= oct3_q;
      p4_q   <= 47'(p3_q) * 47'(ps3_q);
      fs4_q  <= fs3_q;
    end
    if (ld_i.s5) begin
      oct5_q <= oct4_q;
      p5_q   <= 63'(p4_q) * 63'(fs4_q);
    end
  end

  assign shamt   = 6'd51 - oct5_q;
  assign shifted = p5_q >> shamt;
  assign incr_o  = (|shifted[62:24]) ? 24'hFF_FFFF : shifted[23:0];

endmodule

// ===== design/wavetable_oscillator_sample_core.sv =====
// top level of the wavetable oscillator: table store, lookup, blend and phase advance
//
// channel   | handshake                | payload
// ----------+--------------------------+------------------------------------------------
// in        | in_valid_i / in_ready_o  | command, frame/sample index, table_value, phase,
//           |                          | wt_pos, note, pitch_scale, fm_scale
// out       | out_valid_o / out_ready_i| sample_out, next_phase
// cfg       | cfg_we_i                 | cfg_index_i, cfg_data_i (write only)
//
// six register stages; one word enters per cycle while the pipeline is not stalled
// table writes travel to the memory stage in order and end there, no output word
// each stage holds while the stage after it is full and stalled, bubbles fill in
// async active-low reset clears valid bits and sets config to defaults; the table is undefined until written
`timescale 1ns / 1ps
module wavetable_oscillator_sample_core import wos_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [4:0]         frame_index_i,
  input  logic [9:0]         sample_index_i,
  input  logic signed [15:0] table_value_i,
  input  logic [23:0]        phase_i,
  input  logic [16:0]        wt_pos_i,
  input  logic [6:0]         note_i,
  input  logic [15:0]        pitch_scale_i,
  input  logic [15:0]        fm_scale_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o,
  output logic [23:0]        next_phase_o
);

  // configuration registers
  logic               enabled_q, smooth_q;
  logic signed [15:0] detune_q;
  logic [23:0]        ref_increment_q;
  logic [5:0]         frame_count_q;
  logic [10:0]        frame_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q       <= 1'b0;
      smooth_q        <= 1'b0;
      detune_q        <= '0;
      ref_increment_q <= 24'd153791;
      frame_count_q   <= 6'd1;
      frame_length_q  <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ENABLED:       enabled_q       <= cfg_data_i[0];
        REG_SMOOTH:        smooth_q        <= cfg_data_i[0];
        REG_DETUNE:        detune_q        <= cfg_data_i[15:0];
        REG_REF_INCREMENT: ref_increment_q <= cfg_data_i;
        REG_FRAME_COUNT:   frame_count_q   <= cfg_data_i[5:0];
        REG_FRAME_LENGTH:  frame_length_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and backward load chain
  logic [6:1] v_q;
  logic [7:1] adv;

  always_comb begin
    adv[7] = out_ready_i;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[1];
  assign out_valid_o = v_q[6];

  // stage 1: clamp config, pick frame, split phase into index and fraction
  logic [5:0]  count;
  logic [10:0] len;
  logic [22:0] frame_prod;
  logic [6:0]  frame_raw;
  logic [4:0]  frame;
  logic [34:0] pos_prod;
  logic [9:0]  idx;
  logic [10:0] nidx_full;
  logic [9:0]  nidx;

  always_comb begin
    if (frame_count_q == 6'd0)       count = 6'd1;
    else if (frame_count_q > 6'd32)  count = 6'd32;
    else                             count = frame_count_q;
    if (frame_length_q < 11'd2)          len = 11'd2;
    else if (frame_length_q > 11'd1024)  len = 11'd1024;
    else                                 len = frame_length_q;
    frame_prod = 23'(wt_pos_i) * 23'(count);
    frame_raw  = frame_prod[22:16];
    // wt_pos at the end saturates to the last frame
    frame      = (frame_raw >= 7'(count)) ? 5'(count - 6'd1) : frame_raw[4:0];
    pos_prod   = 35'(phase_i) * 35'(len);
    idx        = pos_prod[33:24];
    nidx_full  = 11'(idx) + 11'd1;
    // blending past the last sample wraps to the frame start
    nidx       = (nidx_full >= len) ? 10'd0 : nidx_full[9:0];
  end

  logic                cmd1_q;
  logic [AddrBits-1:0] addr0_1_q, addr1_1_q;
  logic [15:0]         wdata1_q;
  logic [23:0]         frac1_q, phase1_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      cmd1_q   <= command_i;
      frac1_q  <= pos_prod[23:0];
      phase1_q <= phase_i;
      wdata1_q <= table_value_i;
      if (command_i == CMD_READ) begin
        addr0_1_q <= {frame, idx};
        addr1_1_q <= {frame, nidx};
      end else begin
        addr0_1_q <= {frame_index_i, sample_index_i};
        addr1_1_q <= {frame_index_i, sample_index_i};
      end
    end
  end

  // stage 2: table memory, one write or a two-word read per word
  logic [15:0] mem [MaxFrames*MaxFrameLen];
  logic [15:0] rd0_q, rd1_q;
  logic [23:0] frac2_q, phase2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2] && v_q[1] && (cmd1_q == CMD_WRITE)) begin
      mem[addr0_1_q] <= wdata1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      rd0_q    <= mem[addr0_1_q];
      rd1_q    <= mem[addr1_1_q];
      frac2_q  <= frac1_q;
      phase2_q <= phase1_q;
    end
  end

  // stage 3: blend products on offset-binary samples
  logic [39:0] pa3_q, pb3_q;
  logic [15:0] s3_q;
  logic [23:0] phase3_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      pa3_q    <= 40'(rd0_q ^ 16'h8000) * (40'd1 << 24) - 40'(rd0_q ^ 16'h8000) * 40'(frac2_q);
      pb3_q    <= 40'(rd1_q ^ 16'h8000) * 40'(frac2_q);
      s3_q     <= rd0_q;
      phase3_q <= phase2_q;
    end
  end

  // stage 4: with smooth, sum, round half up, back to two's complement; else the first sample
  logic [39:0] blend_sum;
  logic [15:0] s4_q;
  logic [23:0] phase4_q;

  assign blend_sum = pa3_q + pb3_q + (40'd1 << 23);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_q     <= smooth_q ? (blend_sum[39:24] ^ 16'h8000) : s3_q;
      phase4_q <= phase3_q;
    end
  end

  // stage 5: wait for the increment pipeline
  logic [15:0] s5_q;
  logic [23:0] phase5_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_q     <= s4_q;
      phase5_q <= phase4_q;
    end
  end

  // increment pipeline runs beside stages one to five
  load_t       ld;
  logic [23:0] incr;

  assign ld.s1 = adv[1];
  assign ld.s2 = adv[2];
  assign ld.s3 = adv[3];
  assign ld.s4 = adv[4];
  assign ld.s5 = adv[5];

  wos_pitch u_pitch (
    .clk_i          (clk_i),
    .ld_i           (ld),
    .note_i         (note_i),
    .detune_i       (detune_q),
    .ref_increment_i(ref_increment_q),
    .pitch_scale_i  (pitch_scale_i),
    .fm_scale_i     (fm_scale_i),
    .incr_o         (incr)
  );

  // stage 6: output register; disabled gives silence and holds the phase
  logic [15:0] s6_q;
  logic [23:0] phase6_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_q     <= enabled_q ? s5_q : 16'd0;
      phase6_q <= enabled_q ? (phase5_q + incr) : phase5_q;
    end
  end

  assign sample_out_o = s6_q;
  assign next_phase_o = phase6_q;

  // cmd2_q tracks the command held in stage 2
  logic cmd2_q;
  always_ff @(posedge clk_i) begin
    if (adv[2]) cmd2_q <= cmd1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_valid_i;
      if (adv[2]) v_q[2] <= v_q[1];
      // table writes end at the memory stage
      if (adv[3]) v_q[3] <= v_q[2] && (cmd2_q == CMD_READ);
      if (adv[4]) v_q[4] <= v_q[3];
      if (adv[5]) v_q[5] <= v_q[4];
      if (adv[6]) v_q[6] <= v_q[5];
    end
  end

  logic drop_s2;
  assign drop_s2 = v_q[2] && (cmd2_q == CMD_WRITE);

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input blocked while a stage is empty");

  a_no_write_past_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv[3] && drop_s2) |=> !v_q[3])
    else $error("table write reached the blend stage");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && adv[5]) |=> v_q[5])
    else $error("word lost between stages");

endmodule
